[sv/vqda_pkg.sv]
// Shared types and constants for the virtqueue descriptor allocator.
// Holds the input and result item structs and the controller command and status structs.
// No dependencies.
package vqda_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_FREED    = 2'd3;

  // Input item kinds
  localparam logic KIND_SUBMIT  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Descriptor slots of a submitted chain
  localparam logic [1:0] SLOT_HDR  = 2'd0;
  localparam logic [1:0] SLOT_DATA = 2'd1;
  localparam logic [1:0] SLOT_STAT = 2'd2;

  typedef struct packed {
    logic        kind;
    logic        is_write;
    logic [31:0] block_number;
    logic [7:0]  release_head;
  } vqda_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  first_index;
    logic [7:0]  second_index;
    logic [7:0]  third_index;
    logic [7:0]  ring_slot;
    logic [15:0] avail_after;
    logic        data_writable;
    logic [38:0] sector;
    logic [8:0]  freed_count;
  } vqda_out_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;          // capture the accepted item
    logic       find;          // pick lowest free descriptor into slot
    logic       link_wr;       // write link of the descriptor in slot
    logic [1:0] slot;
    logic       commit;        // take picks, advance avail, emit ok result
    logic       emit_nospace;  // emit pool-full result
    logic       rel_free;      // free cur, read its link
    logic       rel_next;      // follow the link just read
    logic       emit_release;  // emit release result with code
    logic [1:0] code;
  } vqda_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;        // a free descriptor is available for find
    logic range_bad;  // cur is outside the pool
    logic cur_free;   // cur is already free
    logic more;       // link just read has a successor
  } vqda_stat_t;

endpackage

[sv/virtqueue_descriptor_allocator.sv]
// Virtqueue descriptor allocator top level: sequencer plus datapath.
// Submit: three searches, three link writes, result; a full pool ends the search.
// Release: a check and a link read per freed descriptor, one more check if the walk stops
// on a bad link or head. Result strobe: the cycle after the last work cycle; no receiver stall.
// Reset (synchronous, rst_n low): all descriptors free, avail count zero, sectors_per_block 1.
// Depends on vqda_pkg, vqda_ctrl, vqda_dp, vqda_ram.
module virtqueue_descriptor_allocator #(
  parameter int POOL_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vqda_pkg::vqda_in_t  in_data,
  output logic                out_valid,
  output vqda_pkg::vqda_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import vqda_pkg::*;

  vqda_cmd_t  cmd;
  vqda_stat_t stat;
  logic       accept;

  // Items are taken only while the sequencer is idle
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  vqda_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .in_kind (in_data.kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  vqda_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[sv/vqda_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module vqda_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/vqda_ctrl.sv]
// Sequencer for the descriptor allocator: submit search and link writes, release walk.
// Depends on vqda_pkg for the command and status structs.
module vqda_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_kind,
  input  vqda_pkg::vqda_stat_t stat,
  output vqda_pkg::vqda_cmd_t  cmd,
  output logic                busy
);
  import vqda_pkg::*;

  typedef enum logic [8:0] {
    IDLE  = 9'b000000001,
    FIND0 = 9'b000000010,
    FIND1 = 9'b000000100,
    FIND2 = 9'b000001000,
    LINK0 = 9'b000010000,
    LINK1 = 9'b000100000,
    LINK2 = 9'b001000000,
    RCHK  = 9'b010000000,
    RWAIT = 9'b100000000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_kind == KIND_RELEASE) ? RCHK : FIND0;
        end
      end
      FIND0, FIND1, FIND2: begin
        cmd.slot = (state_r == FIND0) ? SLOT_HDR :
                   (state_r == FIND1) ? SLOT_DATA : SLOT_STAT;
        if (stat.hit) begin
          cmd.find  = 1'b1;
          state_nxt = (state_r == FIND0) ? FIND1 :
                      (state_r == FIND1) ? FIND2 : LINK0;
        end else begin
          cmd.emit_nospace = 1'b1;
          state_nxt        = IDLE;
        end
      end
      LINK0: begin
        cmd.link_wr = 1'b1;
        cmd.slot    = SLOT_HDR;
        state_nxt   = LINK1;
      end
      LINK1: begin
        cmd.link_wr = 1'b1;
        cmd.slot    = SLOT_DATA;
        state_nxt   = LINK2;
      end
      LINK2: begin
        cmd.link_wr = 1'b1;
        cmd.slot    = SLOT_STAT;
        cmd.commit  = 1'b1;
        state_nxt   = IDLE;
      end
      RCHK: begin
        if (stat.range_bad) begin
          cmd.emit_release = 1'b1;
          cmd.code         = ST_RANGE;
          state_nxt        = IDLE;
        end else if (stat.cur_free) begin
          cmd.emit_release = 1'b1;
          cmd.code         = ST_FREED;
          state_nxt        = IDLE;
        end else begin
          cmd.rel_free = 1'b1;
          state_nxt    = RWAIT;
        end
      end
      RWAIT: begin
        // link of the freed entry is on the RAM output now
        if (stat.more) begin
          cmd.rel_next = 1'b1;
          state_nxt    = RCHK;
        end else begin
          cmd.emit_release = 1'b1;
          cmd.code         = ST_OK;
          state_nxt        = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  assign busy = (state_r != IDLE);

endmodule

[sv/vqda_dp.sv]
// Datapath of the descriptor allocator: free map, picks, link RAM, counters, result register.
// Depends on vqda_pkg and vqda_ram.
module vqda_dp #(
  parameter int POOL_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vqda_pkg::vqda_in_t   in_data,
  input  vqda_pkg::vqda_cmd_t  cmd,
  output vqda_pkg::vqda_stat_t stat,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_data,
  output logic                 out_valid,
  output vqda_pkg::vqda_out_t  out_data
);
  import vqda_pkg::*;

  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int LINK_W = IDX_W + 1;

  // Control state
  logic [POOL_DEPTH-1:0] free_map_r;
  logic [15:0]           avail_r;
  logic [IDX_W-1:0]      slot_r;
  logic [7:0]            spb_r;
  logic                  out_valid_r;

  // Item payload
  logic                  is_write_r;
  logic [31:0]           block_r;
  logic [7:0]            cur_r;
  logic [POOL_DEPTH-1:0] taken_r;
  logic [8:0]            freed_r;
  logic [IDX_W-1:0]      pick0_r, pick1_r, pick2_r;
  logic [38:0]           sector_r;
  vqda_out_t             out_r;

  logic [IDX_W:0]        ffs_w;
  logic [39:0]           prod_w;
  logic [IDX_W-1:0]      cur_idx_w;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [LINK_W-1:0]     ram_wdata;
  logic [LINK_W-1:0]     ram_rdata;
  logic [IDX_W-1:0]      slot_nxt;

  // Lowest set bit, with a found flag on top
  function automatic logic [IDX_W:0] find_first(input logic [POOL_DEPTH-1:0] v);
    logic [IDX_W:0] res;
    res = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) begin
        res = {1'b1, IDX_W'(i)};
      end
    end
    return res;
  endfunction

  assign ffs_w     = find_first(free_map_r & ~taken_r);
  assign prod_w    = 40'(block_r) * 40'(spb_r);
  assign cur_idx_w = cur_r[IDX_W-1:0];

  // Status back to the sequencer
  assign stat.hit       = ffs_w[IDX_W];
  assign stat.range_bad = ({1'b0, cur_r} >= 9'(POOL_DEPTH));
  assign stat.cur_free  = free_map_r[cur_idx_w];
  assign stat.more      = ram_rdata[IDX_W];

  // Link writes: header -> data -> status, status has no successor
  always_comb begin
    ram_we    = cmd.link_wr;
    ram_waddr = pick0_r;
    ram_wdata = {1'b1, pick1_r};
    case (cmd.slot)
      SLOT_HDR: begin
        ram_waddr = pick0_r;
        ram_wdata = {1'b1, pick1_r};
      end
      SLOT_DATA: begin
        ram_waddr = pick1_r;
        ram_wdata = {1'b1, pick2_r};
      end
      default: begin
        ram_waddr = pick2_r;
        ram_wdata = '0;
      end
    endcase
  end

  // A free entry's link is never read, so release leaves the RAM alone
  vqda_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rel_free),
    .raddr (cur_idx_w),
    .rdata (ram_rdata)
  );

  // Ring slot follows avail modulo pool depth, restarting when avail wraps
  always_comb begin
    if (avail_r == 16'hffff) begin
      slot_nxt = '0;
    end else if (slot_r == IDX_W'(POOL_DEPTH - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + IDX_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r  <= '1;
      avail_r     <= '0;
      slot_r      <= '0;
      spb_r       <= 8'd1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit | cmd.emit_nospace | cmd.emit_release;
      if (cfg_valid) begin
        spb_r <= cfg_data;
      end
      if (cmd.commit) begin
        free_map_r <= free_map_r & ~taken_r;
        avail_r    <= avail_r + 16'd1;
        slot_r     <= slot_nxt;
      end
      if (cmd.rel_free) begin
        free_map_r[cur_idx_w] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_write_r <= in_data.is_write;
      block_r    <= in_data.block_number;
      cur_r      <= in_data.release_head;
      taken_r    <= '0;
      freed_r    <= '0;
    end
    if (cmd.find) begin
      taken_r[ffs_w[IDX_W-1:0]] <= 1'b1;
      case (cmd.slot)
        SLOT_HDR: begin
          pick0_r  <= ffs_w[IDX_W-1:0];
          sector_r <= prod_w[38:0];
        end
        SLOT_DATA: pick1_r <= ffs_w[IDX_W-1:0];
        default:   pick2_r <= ffs_w[IDX_W-1:0];
      endcase
    end
    if (cmd.rel_free) begin
      freed_r <= freed_r + 9'd1;
    end
    if (cmd.rel_next) begin
      cur_r <= 8'(ram_rdata[IDX_W-1:0]);
    end
    // Result register
    if (cmd.commit) begin
      out_r.status        <= ST_OK;
      out_r.first_index   <= 8'(pick0_r);
      out_r.second_index  <= 8'(pick1_r);
      out_r.third_index   <= 8'(pick2_r);
      out_r.ring_slot     <= 8'(slot_r);
      out_r.avail_after   <= avail_r + 16'd1;
      out_r.data_writable <= ~is_write_r;
      out_r.sector        <= sector_r;
      out_r.freed_count   <= '0;
    end else if (cmd.emit_nospace || cmd.emit_release) begin
      out_r.status        <= cmd.emit_nospace ? ST_NO_SPACE : cmd.code;
      out_r.first_index   <= '0;
      out_r.second_index  <= '0;
      out_r.third_index   <= '0;
      out_r.ring_slot     <= '0;
      out_r.avail_after   <= avail_r;
      out_r.data_writable <= 1'b0;
      out_r.sector        <= '0;
      out_r.freed_count   <= cmd.emit_nospace ? 9'd0 : freed_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_commit_three: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $countones(taken_r) == 3)
    else $error("submit commit without exactly three picks");
  a_picks_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (pick0_r < pick1_r) && (pick1_r < pick2_r))
    else $error("picks not in ascending order");
  a_free_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rel_free |-> !stat.range_bad && !stat.cur_free)
    else $error("release frees an invalid or free descriptor");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slot_r) < POOL_DEPTH)
    else $error("ring slot outside pool");
`endif

endmodule

[dv/virtqueue_descriptor_allocator_tb.sv]
// Self-checking testbench for the virtqueue descriptor allocator.
// Drives submit and release items, predicts each result from its own model of the pool.
// Depends on vqda_pkg and virtqueue_descriptor_allocator.
`timescale 1ns / 100ps

module virtqueue_descriptor_allocator_tb;
  import vqda_pkg::*;

  localparam int POOL = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 258;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  vqda_in_t  in_data = '0;
  logic      out_valid;
  vqda_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  // Model of the pool, updated as each item is accepted
  logic        free_q [POOL];
  logic [7:0]  link_q [POOL];
  logic        chain_q[POOL];
  logic        head_q [POOL];   // marks chain heads, only used to steer stimulus
  logic [15:0] avail_q;
  logic [7:0]  spb_q;

  vqda_out_t pending_results[$];
  int        err_cnt = 0;
  int        stall_cycles = 0;

  virtqueue_descriptor_allocator #(.POOL_DEPTH(POOL)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < POOL; i++) begin
      free_q[i] = 1'b1;
      link_q[i] = '0;
      chain_q[i] = 1'b0;
      head_q[i] = 1'b0;
    end
    avail_q = '0;
    spb_q = 8'd1;
  end

  // Allocate or release against the pool model; returns the expected result
  function automatic vqda_out_t predict_alloc(vqda_in_t it);
    vqda_out_t  r;
    int         picks[3];
    int         cnt;
    int         cur;
    logic       more;
    logic [7:0] nxt;
    logic [39:0] prod;
    r = '0;
    cnt = 0;
    if (it.kind == KIND_SUBMIT) begin
      for (int i = 0; i < POOL; i++) begin
        if (free_q[i] && cnt < 3) begin
          picks[cnt] = i;
          cnt++;
        end
      end
      if (cnt < 3) begin
        r.status = ST_NO_SPACE;
        r.avail_after = avail_q;
      end else begin
        for (int k = 0; k < 3; k++) free_q[picks[k]] = 1'b0;
        link_q[picks[0]] = 8'(picks[1]);
        chain_q[picks[0]] = 1'b1;
        link_q[picks[1]] = 8'(picks[2]);
        chain_q[picks[1]] = 1'b1;
        link_q[picks[2]] = '0;
        chain_q[picks[2]] = 1'b0;
        head_q[picks[0]] = 1'b1;
        r.status = ST_OK;
        r.first_index = 8'(picks[0]);
        r.second_index = 8'(picks[1]);
        r.third_index = 8'(picks[2]);
        r.ring_slot = 8'(avail_q % POOL);
        avail_q = avail_q + 16'd1;
        r.avail_after = avail_q;
        r.data_writable = ~it.is_write;
        prod = 40'(it.block_number) * 40'(spb_q);
        r.sector = prod[38:0];
      end
    end else begin
      // walk the chain; stop on a link that leaves the pool or hits a free entry
      cur = int'(it.release_head);
      r.status = ST_OK;
      for (int s = 0; s <= POOL; s++) begin
        if (cur >= POOL) begin
          r.status = ST_RANGE;
          break;
        end
        if (free_q[cur]) begin
          r.status = ST_FREED;
          break;
        end
        more = chain_q[cur];
        nxt = link_q[cur];
        free_q[cur] = 1'b1;
        link_q[cur] = '0;
        chain_q[cur] = 1'b0;
        head_q[cur] = 1'b0;
        cnt++;
        if (!more) break;
        cur = int'(nxt);
      end
      r.avail_after = avail_q;
      r.freed_count = 9'(cnt);
    end
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s differs, expected %0h actual %0h", $time, fname, want, got);
    end
  endtask

  task automatic compare_result(input vqda_out_t want, input vqda_out_t got);
    check_field("status", want.status, got.status);
    check_field("first_index", want.first_index, got.first_index);
    check_field("second_index", want.second_index, got.second_index);
    check_field("third_index", want.third_index, got.third_index);
    check_field("ring_slot", want.ring_slot, got.ring_slot);
    check_field("avail_after", want.avail_after, got.avail_after);
    check_field("data_writable", want.data_writable, got.data_writable);
    check_field("sector", want.sector, got.sector);
    check_field("freed_count", want.freed_count, got.freed_count);
  endtask

  // Sample handshakes at the rising edge: results first, then the accepted item
  always @(posedge clk) begin : monitor
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none actual %p", $time, out_data);
        end else begin
          compare_result(pending_results.pop_front(), out_data);
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        pending_results.push_back(predict_alloc(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        spb_q = cfg_data;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog: too long without any handshake
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  function automatic vqda_in_t submit_item(input logic wr, input logic [31:0] bn);
    vqda_in_t it;
    it.kind = KIND_SUBMIT;
    it.is_write = wr;
    it.block_number = bn;
    it.release_head = 8'($urandom);
    return it;
  endfunction

  function automatic vqda_in_t release_item(input logic [7:0] head);
    vqda_in_t it;
    it.kind = KIND_RELEASE;
    it.is_write = 1'($urandom);
    it.block_number = $urandom;
    it.release_head = head;
    return it;
  endfunction

  // Present one item and hold it until taken; start stays high on return
  task automatic send_item(input vqda_in_t it);
    @(negedge clk);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= vqda_in_t'(42'({$urandom, $urandom}));
    end
  endtask

  // Register write only once the block has drained
  task automatic write_spb(input logic [7:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= 8'($urandom);
  endtask

  // Mostly well-formed traffic: submits and releases of live chain heads
  task automatic pick_item(output vqda_in_t it);
    int          sel;
    int          cand[$];
    logic [31:0] bn;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: bn = '0;
      1: bn = '1;
      default: bn = $urandom;
    endcase
    if (sel < 45) begin
      it = submit_item(1'($urandom), bn);
    end else begin
      for (int i = 0; i < POOL; i++) begin
        if (!free_q[i] && (sel >= 80 || head_q[i])) cand.push_back(i);
      end
      if (sel < 90 && cand.size() > 0) begin
        it = release_item(8'(cand[$urandom_range(0, cand.size() - 1)]));
      end else begin
        it = release_item(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Allocation order, pool full, bad heads and a broken chain walk
  task automatic test_chain_alloc_release();
    send_item(submit_item(1'b0, 32'h0000_0000));
    send_item(submit_item(1'b1, 32'hFFFF_FFFF));
    send_item(submit_item(1'b0, 32'h5A5A_5A5A));   // only two left
    idle_cycles($urandom_range(0, 3));
    send_item(release_item(8'd3));
    send_item(release_item(8'd3));                 // already free
    send_item(release_item(8'd8));                 // first index past the pool
    idle_cycles($urandom_range(0, 3));
    send_item(release_item(8'd255));
    send_item(release_item(8'd1));                 // middle of a chain
    send_item(release_item(8'd0));                 // link now points at a free entry
    send_item(release_item(8'd7));                 // never allocated
    idle_cycles($urandom_range(0, 3));
    send_item(submit_item(1'b1, 32'h0000_0001));
    send_item(submit_item(1'b0, 32'hA5A5_A5A5));
    send_item(release_item(8'd0));
    send_item(release_item(8'd3));
  endtask

  // Scaling extremes, including wrap of the product and a zero multiplier
  task automatic test_sector_scaling();
    write_spb(8'd128);
    send_item(submit_item(1'b0, 32'hFFFF_FFFF));
    send_item(release_item(8'd0));
    write_spb(8'd255);
    send_item(submit_item(1'b1, 32'hFFFF_FFFF));
    send_item(release_item(8'd0));
    write_spb(8'd0);
    send_item(submit_item(1'b0, 32'h1234_5678));
    send_item(release_item(8'd0));
  endtask

  // Random traffic in bursts with random gaps under one register setting
  task automatic test_random_traffic(input logic [7:0] spb, input int n_items);
    int       sent;
    int       burst;
    vqda_in_t it;
    write_spb(spb);
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        pick_item(it);
        send_item(it);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_chain_alloc_release();
    test_sector_scaling();
    test_random_traffic(8'd1, PHASE_ITEMS);
    test_random_traffic(8'd128, PHASE_ITEMS);
    test_random_traffic(8'd0, PHASE_ITEMS);
    test_random_traffic(8'd255, PHASE_ITEMS);
    test_random_traffic(8'($urandom_range(1, 128)), PHASE_ITEMS);
    test_random_traffic(8'($urandom), PHASE_ITEMS);

    // drain and let the block settle
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
sv/vqda_pkg.sv
sv/vqda_ram.sv
sv/vqda_ctrl.sv
sv/vqda_dp.sv
sv/virtqueue_descriptor_allocator.sv
dv/virtqueue_descriptor_allocator_tb.sv
